[sv/bpa_pkg.sv]
// Shared types and constants for the best-fit page allocator.
// Used by bpa_ctrl, bpa_datapath and the top level; no dependencies.
package bpa_pkg;

   localparam int unsigned DEF_PAGE_BYTES = 4096;
   localparam int unsigned DEF_NUM_PAGES  = 4096;

   localparam logic [1:0] CMD_MARK_USED = 2'd0;
   localparam logic [1:0] CMD_MARK_FREE = 2'd1;
   localparam logic [1:0] CMD_ALLOC     = 2'd2;
   localparam logic [1:0] CMD_FREE      = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_NO_FIT   = 2'd2;
   localparam logic [1:0] ST_NOT_ALOC = 2'd3;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_LOAD,
      OP_MARK_INIT,
      OP_WALK,
      OP_SCAN_INIT,
      OP_SCAN,
      OP_SCAN_FINAL,
      OP_FILL_INIT,
      OP_FREE_INIT,
      OP_RESP
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] status;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       clear_last;
      logic       empty_range;
      logic       zero_size;
      logic       free_bad;
      logic       len_zero;
      logic       walk_done;
      logic       scan_done;
      logic       fit;
      logic       rsp_busy;
   } dp_stat_type;

endpackage

[sv/bpa_datapath.sv]
// Datapath of the page allocator: use map and length memories, page walker,
// run scanner and response register. Depends on bpa_pkg.
module bpa_datapath
   import bpa_pkg::*;
#(
   parameter int unsigned PAGE_BYTES = DEF_PAGE_BYTES,
   parameter int unsigned NUM_PAGES  = DEF_NUM_PAGES
) (
   input  logic        clock,
   input  logic        reset,
   input  ctl_cmd_type ctl,
   output dp_stat_type stat,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_start_address,
   input  logic [31:0] req_end_address,
   input  logic [31:0] req_request_bytes,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [23:0] rsp_result_address
);

   localparam int LOG = $clog2(PAGE_BYTES);
   localparam int PW  = $clog2(NUM_PAGES);
   localparam int CW  = PW + 1;
   localparam int NW  = 33 - LOG;
   localparam logic [CW-1:0] NUM_C = CW'(NUM_PAGES);

   logic          use_mem [NUM_PAGES];
   logic [CW-1:0] len_mem [NUM_PAGES];

   logic [1:0]    cmd_ff;
   logic [31:0]   start_ff, end_ff, bytes_ff;
   logic [CW-1:0] cnt_ff, cnt_in, lim_ff, lim_in;
   logic          bit_ff, bit_in;
   logic [PW-1:0] run_start_ff, run_start_in, best_start_ff, best_start_in;
   logic [CW-1:0] run_len_ff, run_len_in, best_len_ff, best_len_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [PW-1:0] rd_page_ff;
   logic          use_rd_ff;
   logic [CW-1:0] len_rd_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [23:0]   rsp_addr_ff, rsp_addr_in;

   logic [31:0]   first_w;
   logic [32:0]   past_w, need_full;
   logic [CW-1:0] past_clip, mark_first;
   logic [NW-1:0] need_w;
   logic [PW-1:0] page_idx;
   logic [CW:0]   free_end;
   logic [CW-1:0] free_lim;
   logic          run_ok, walk_done;

   assign first_w    = start_ff >> LOG;
   assign past_w     = ({1'b0, end_ff} + 33'(PAGE_BYTES - 1)) >> LOG;
   assign past_clip  = (past_w > 33'(NUM_PAGES)) ? NUM_C : past_w[CW-1:0];
   assign mark_first = ({1'b0, first_w} >= 33'(past_clip)) ? past_clip : first_w[CW-1:0];
   assign need_full  = ({1'b0, bytes_ff} + 33'(PAGE_BYTES - 1)) >> LOG;
   assign need_w     = need_full[NW-1:0];
   assign page_idx   = first_w[PW-1:0];
   assign free_end   = (CW+1)'(page_idx) + (CW+1)'(len_rd_ff);
   assign free_lim   = (free_end > (CW+1)'(NUM_PAGES)) ? NUM_C : free_end[CW-1:0];
   assign walk_done  = (cnt_ff == lim_ff);
   assign run_ok     = (run_len_ff != '0) && (NW'(run_len_ff) >= need_w)
                       && (run_len_ff < best_len_ff);

   assign stat.cmd         = cmd_ff;
   assign stat.clear_last  = (cnt_ff == CW'(NUM_PAGES - 1));
   assign stat.empty_range = (start_ff >= end_ff);
   assign stat.zero_size   = (bytes_ff == '0);
   assign stat.free_bad    = (start_ff[LOG-1:0] != '0) || (first_w >= 32'(NUM_PAGES));
   assign stat.len_zero    = (len_rd_ff == '0);
   assign stat.walk_done   = walk_done;
   assign stat.scan_done   = (cnt_ff == NUM_C) && !rd_vld_ff;
   assign stat.fit         = (best_len_ff != '1);
   assign stat.rsp_busy    = rsp_valid_ff;

   always_comb begin
      cnt_in        = cnt_ff;
      lim_in        = lim_ff;
      bit_in        = bit_ff;
      run_start_in  = run_start_ff;
      run_len_in    = run_len_ff;
      best_start_in = best_start_ff;
      best_len_in   = best_len_ff;
      rd_vld_in     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      case (ctl.op)
         OP_CLEAR: cnt_in = cnt_ff + 1'b1;
         OP_MARK_INIT: begin
            cnt_in = mark_first;
            lim_in = past_clip;
            bit_in = (cmd_ff == CMD_MARK_USED);
         end
         OP_WALK: if (!walk_done) cnt_in = cnt_ff + 1'b1;
         OP_SCAN_INIT: begin
            cnt_in        = '0;
            run_start_in  = '0;
            run_len_in    = '0;
            best_start_in = '0;
            best_len_in   = '1;
         end
         OP_SCAN: begin
            if (cnt_ff != NUM_C) begin
               cnt_in    = cnt_ff + 1'b1;
               rd_vld_in = 1'b1;
            end
            if (rd_vld_ff) begin
               if (!use_rd_ff) begin
                  if (run_len_ff == '0) run_start_in = rd_page_ff;
                  run_len_in = run_len_ff + 1'b1;
               end else begin
                  if (run_ok) begin
                     best_start_in = run_start_ff;
                     best_len_in   = run_len_ff;
                  end
                  run_len_in = '0;
               end
            end
         end
         OP_SCAN_FINAL: begin
            if (run_ok) begin
               best_start_in = run_start_ff;
               best_len_in   = run_len_ff;
            end
         end
         OP_FILL_INIT: begin
            cnt_in = CW'(best_start_ff);
            lim_in = CW'(best_start_ff) + need_w[CW-1:0];
            bit_in = 1'b1;
         end
         OP_FREE_INIT: begin
            cnt_in = CW'(page_idx);
            lim_in = free_lim;
            bit_in = 1'b0;
         end
         OP_RESP: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = ctl.status;
            rsp_addr_in   = (ctl.status == ST_OK && cmd_ff == CMD_ALLOC)
                            ? 24'(32'(best_start_ff) << LOG) : '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         lim_ff        <= '0;
         bit_ff        <= 1'b0;
         run_start_ff  <= '0;
         run_len_ff    <= '0;
         best_start_ff <= '0;
         best_len_ff   <= '1;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         lim_ff        <= lim_in;
         bit_ff        <= bit_in;
         run_start_ff  <= run_start_in;
         run_len_ff    <= run_len_in;
         best_start_ff <= best_start_in;
         best_len_ff   <= best_len_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rd_page_ff    <= cnt_ff[PW-1:0];
      use_rd_ff     <= use_mem[cnt_ff[PW-1:0]];
      len_rd_ff     <= len_mem[page_idx];
      if (ctl.op == OP_LOAD) begin
         cmd_ff   <= req_command;
         start_ff <= req_start_address;
         end_ff   <= req_end_address;
         bytes_ff <= req_request_bytes;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.op == OP_CLEAR) begin
         use_mem[cnt_ff[PW-1:0]] <= 1'b1;
      end else if (ctl.op == OP_WALK && !walk_done) begin
         use_mem[cnt_ff[PW-1:0]] <= bit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.op == OP_CLEAR) begin
         len_mem[cnt_ff[PW-1:0]] <= '0;
      end else if (ctl.op == OP_FILL_INIT) begin
         len_mem[best_start_ff] <= need_w[CW-1:0];
      end else if (ctl.op == OP_FREE_INIT) begin
         len_mem[page_idx] <= '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_address = rsp_addr_ff;

endmodule

[sv/bpa_ctrl.sv]
// Controller of the page allocator: sequences clear, mark, scan, fill and
// free operations of bpa_datapath. Depends on bpa_pkg.
module bpa_ctrl
   import bpa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output ctl_cmd_type ctl
);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_DISPATCH, S_WALK, S_SCAN, S_SCAN_END, S_DECIDE, S_FREE_CHK
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE) && !stat.rsp_busy;

   always_comb begin
      state_in   = state_ff;
      ctl.op     = OP_NONE;
      ctl.status = ST_OK;
      case (state_ff)
         S_CLEAR: begin
            ctl.op = OP_CLEAR;
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid && req_ready) begin
               ctl.op   = OP_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.cmd)
               CMD_MARK_USED, CMD_MARK_FREE: begin
                  if (stat.empty_range) begin
                     ctl.op     = OP_RESP;
                     ctl.status = ST_EMPTY;
                     state_in   = S_IDLE;
                  end else begin
                     ctl.op   = OP_MARK_INIT;
                     state_in = S_WALK;
                  end
               end
               CMD_ALLOC: begin
                  if (stat.zero_size) begin
                     ctl.op     = OP_RESP;
                     ctl.status = ST_EMPTY;
                     state_in   = S_IDLE;
                  end else begin
                     ctl.op   = OP_SCAN_INIT;
                     state_in = S_SCAN;
                  end
               end
               default: begin
                  if (stat.free_bad) begin
                     ctl.op     = OP_RESP;
                     ctl.status = ST_NOT_ALOC;
                     state_in   = S_IDLE;
                  end else begin
                     state_in = S_FREE_CHK;
                  end
               end
            endcase
         end
         S_WALK: begin
            if (stat.walk_done) begin
               ctl.op   = OP_RESP;
               state_in = S_IDLE;
            end else begin
               ctl.op = OP_WALK;
            end
         end
         S_SCAN: begin
            ctl.op = OP_SCAN;
            if (stat.scan_done) state_in = S_SCAN_END;
         end
         S_SCAN_END: begin
            ctl.op   = OP_SCAN_FINAL;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (stat.fit) begin
               ctl.op   = OP_FILL_INIT;
               state_in = S_WALK;
            end else begin
               ctl.op     = OP_RESP;
               ctl.status = ST_NO_FIT;
               state_in   = S_IDLE;
            end
         end
         S_FREE_CHK: begin
            if (stat.len_zero) begin
               ctl.op     = OP_RESP;
               ctl.status = ST_NOT_ALOC;
               state_in   = S_IDLE;
            end else begin
               ctl.op   = OP_FREE_INIT;
               state_in = S_WALK;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/bitmap_page_allocator_best_fit_top.sv]
// Best-fit page allocator: one use bit and one allocation length per page.
// Instantiates bpa_ctrl and bpa_datapath; depends on bpa_pkg.
//
// Request channel (req_*): command, byte range or allocation address, and
// request size. Response channel (rsp_*): status and page address, exactly
// one response beat per request beat.
// One request is in work at a time; req_ready is high only while the block
// is idle and the response register is empty.
// Work per request, set by the one-page-per-cycle walk over the map memory:
//   mark used / free : a walk over the pages in the clipped range
//   allocate         : a scan of all NUM_PAGES pages, then a walk over the pages allocated
//   free             : a walk over the pages released; none when the page holds no allocation
//   other errors     : no walk, the response follows the check
// After reset a clearing pass marks every page used and zeroes all lengths;
// req_ready stays low until it ends.
// A stalled response holds in its register and blocks the next request
// until rsp_ready takes it.
module bitmap_page_allocator_best_fit_top
   import bpa_pkg::*;
#(
   parameter int unsigned PAGE_BYTES = DEF_PAGE_BYTES,
   parameter int unsigned NUM_PAGES  = DEF_NUM_PAGES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_start_address,
   input  logic [31:0] req_end_address,
   input  logic [31:0] req_request_bytes,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [23:0] rsp_result_address
);

   ctl_cmd_type ctl;
   dp_stat_type stat;

   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   bpa_datapath #(
      .PAGE_BYTES (PAGE_BYTES),
      .NUM_PAGES  (NUM_PAGES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .stat               (stat),
      .req_command        (req_command),
      .req_start_address  (req_start_address),
      .req_end_address    (req_end_address),
      .req_request_bytes  (req_request_bytes),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_result_address (rsp_result_address)
   );

   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("request taken while a response is pending");

   a_err_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_result_address == '0)
      else $error("nonzero address on error response");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken back to back");

endmodule

[bench/bpa_checker.sv]
// Checker for the best-fit page allocator: predicts each response from the
// request beats it sees and compares status and address. Depends on bpa_pkg.
module bpa_checker
   import bpa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_start_address,
   input  logic [31:0] req_end_address,
   input  logic [31:0] req_request_bytes,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic [23:0] rsp_result_address,
   output int          fail_count,
   output int          pending,
   output int          alloc_ok,
   output int          rsp_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned PB = DEF_PAGE_BYTES;
   localparam longint unsigned NP = DEF_NUM_PAGES;

   typedef struct packed {
      logic [1:0]  status;
      logic [23:0] addr;
   } outcome_type;

   logic        page_used [DEF_NUM_PAGES];
   int          page_len  [DEF_NUM_PAGES];
   outcome_type expected_q[$];

   function automatic void paint(longint unsigned first, longint unsigned past, logic v);
      if (past > NP) past = NP;
      for (longint unsigned p = first; p < past; p++) page_used[p] = v;
   endfunction

   function automatic outcome_type allocator_step(logic [1:0] cmd, logic [31:0] sa,
                                                  logic [31:0] ea, logic [31:0] nb);
      outcome_type     o;
      longint unsigned need, pg;
      int              run_s, run_l, best_s, best_l;
      o = '0;
      o.status = ST_OK;
      if (cmd == CMD_MARK_USED || cmd == CMD_MARK_FREE) begin
         if (sa >= ea) o.status = ST_EMPTY;
         else paint(longint'(sa) / PB, (longint'(ea) + PB - 1) / PB, cmd == CMD_MARK_USED);
      end else if (cmd == CMD_ALLOC) begin
         if (nb == 0) o.status = ST_EMPTY;
         else begin
            need = (longint'(nb) + PB - 1) / PB;
            run_s = 0; run_l = 0; best_s = 0; best_l = -1;
            for (int p = 0; p <= int'(NP); p++) begin
               if (p < int'(NP) && !page_used[p]) begin
                  if (run_l == 0) run_s = p;
                  run_l++;
               end else begin
                  if (run_l != 0 && longint'(run_l) >= need &&
                      (best_l < 0 || run_l < best_l)) begin
                     best_s = run_s;
                     best_l = run_l;
                  end
                  run_l = 0;
               end
            end
            if (best_l < 0) o.status = ST_NO_FIT;
            else begin
               paint(best_s, best_s + need, 1'b1);
               page_len[best_s] = int'(need);
               o.addr = 24'(best_s * PB);
            end
         end
      end else begin
         pg = longint'(sa) / PB;
         if ((longint'(sa) % PB) != 0 || pg >= NP || page_len[pg] == 0) o.status = ST_NOT_ALOC;
         else begin
            paint(pg, pg + page_len[pg], 1'b0);
            page_len[pg] = 0;
         end
      end
      return o;
   endfunction

   always @(posedge clock) begin
      outcome_type e;
      if (reset) begin
         for (int p = 0; p < int'(NP); p++) begin
            page_used[p] = 1'b1;
            page_len[p] = 0;
         end
         expected_q.delete();
         fail_count <= 0;
         pending <= 0;
         alloc_ok <= 0;
         rsp_seen <= 0;
      end else begin
         if (req_valid && req_ready) begin
            e = allocator_step(req_command, req_start_address, req_end_address,
                               req_request_bytes);
            expected_q.push_back(e);
            if (req_command == CMD_ALLOC && e.status == ST_OK) alloc_ok <= alloc_ok + 1;
         end
         if (rsp_valid && rsp_ready) begin
            rsp_seen <= rsp_seen + 1;
            if (expected_q.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected response beat: status %0d addr %h",
                           rsp_status, rsp_result_address);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_q.pop_front();
               if (e.status !== rsp_status || e.addr !== rsp_result_address) begin
                  if (fail_count < 10)
                     $display("mismatch: expected status %0d addr %h, got status %0d addr %h",
                              e.status, e.addr, rsp_status, rsp_result_address);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= expected_q.size();
      end
   end
endmodule

[bench/tb.sv]
// Top of the allocator testbench: clock, reset, request stimulus, response
// stalls and verdict. Depends on bpa_pkg, bpa_checker and the allocator RTL.
module tb;
   import bpa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PB = DEF_PAGE_BYTES;
   localparam int WATCHDOG_LIMIT = 60000;

   logic        clock = 0, reset = 1;
   logic        req_valid = 0, req_ready, rsp_valid, rsp_ready = 0;
   logic [1:0]  req_command = CMD_MARK_USED, rsp_status;
   logic [31:0] req_start_address = 0, req_end_address = 0, req_request_bytes = 0;
   logic [23:0] rsp_result_address;
   int          fail_count, pending, alloc_ok, rsp_seen;
   int          tx_idle = 29, rx_idle = 56, hold_cnt = 0, quiet = 0, sent = 0;
   bit          hold_go = 0, hold_done = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   bitmap_page_allocator_best_fit_top dut (.*);

   bpa_checker chk (.*);

   always @(posedge clock) begin
      if (hold_go && !hold_done) begin
         hold_cnt = 500;
         hold_done = 1;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", quiet);
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send(logic [1:0] c, logic [31:0] s, logic [31:0] e, logic [31:0] b);
      int gap;
      req_valid <= 1'b1;
      req_command <= c;
      req_start_address <= s;
      req_end_address <= e;
      req_request_bytes <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
      if ($urandom_range(99) < tx_idle) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0 || rsp_valid) @(posedge clock);
   endtask

   task automatic random_beat();
      int r, pg;
      r = $urandom_range(99);
      pg = $urandom_range(0, 100);
      if (r < 35)
         send(CMD_ALLOC, $urandom, $urandom,
              ($urandom_range(19) == 0) ? $urandom : $urandom_range(1, 6 * PB));
      else if (r < 60)
         send(CMD_FREE, $urandom_range(0, 80) * PB, $urandom, $urandom);
      else if (r < 75)
         send(CMD_MARK_USED, pg * PB + $urandom_range(0, PB - 1),
              (pg + $urandom_range(1, 4)) * PB - $urandom_range(0, PB - 1), $urandom);
      else if (r < 90)
         send(CMD_MARK_FREE, pg * PB + $urandom_range(0, PB - 1),
              (pg + $urandom_range(1, 6)) * PB - $urandom_range(0, PB - 1), $urandom);
      else
         send(2'($urandom), $urandom, $urandom, $urandom);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      send(CMD_MARK_FREE, 32'h0, 32'hFFFF_FFFF, 32'h0);
      send(CMD_ALLOC, 32'h0, 32'h0, 32'h1);
      send(CMD_ALLOC, 32'h0, 32'h0, PB + 1);
      send(CMD_ALLOC, 32'h0, 32'h0, 32'h0);
      send(CMD_ALLOC, 32'h0, 32'h0, 32'hFFFF_FFFF);
      send(CMD_MARK_USED, 5 * PB + 1, 7 * PB, 32'h0);
      send(CMD_MARK_USED, 32'h100, 32'h100, 32'h0);
      send(CMD_MARK_FREE, 32'hFFFF_FFFF, 32'h0, 32'h0);
      send(CMD_MARK_USED, 32'h0100_0000, 32'hFFFF_FFFF, 32'h0);
      send(CMD_MARK_USED, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0);
      send(CMD_FREE, 32'h0, 32'h0, 32'h0);
      send(CMD_FREE, 32'h0, 32'h0, 32'h0);
      send(CMD_FREE, PB + 4, 32'h0, 32'h0);
      send(CMD_FREE, 32'hFFFF_F000, 32'h0, 32'h0);
      send(CMD_MARK_USED, 12 * PB, 12 * PB + 1, 32'h0);
      send(CMD_ALLOC, 32'h0, 32'h0, 3 * PB);
      send(CMD_ALLOC, 32'h0, 32'h0, 4090 * PB);
      send(CMD_FREE, PB, 32'h0, 32'h0);
      send(CMD_ALLOC, 32'h0, 32'h0, 2 * PB);
      send(CMD_MARK_USED, 30 * PB, 31 * PB, 32'h0);
      send(CMD_MARK_USED, 40 * PB, 42 * PB, 32'h0);
      repeat (40) random_beat();
      drain();
      tx_idle = 56;
      rx_idle = 29;
      repeat (40) random_beat();
      drain();
      tx_idle = 0;
      rx_idle = 0;
      hold_go = 1;
      repeat (40) random_beat();
      drain();
      repeat (50) @(posedge clock);
      $display("%0d request beats, %0d responses, %0d successful allocations", sent, rsp_seen,
               alloc_ok);
      $display("covered marks, best-fit allocation, frees and error statuses under stalls");
      if (fail_count == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
